// ===== hdl/pedal_and_button_midi_front_end_core_assert.svh =====
// Assertion macros used by the front end core RTL.
`ifndef PEDAL_AND_BUTTON_MIDI_FRONT_END_CORE_ASSERT_SVH
`define PEDAL_AND_BUTTON_MIDI_FRONT_END_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PBMFE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define PBMFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define PBMFE_ASSERT_IMP(label, clk, rst, ante, cons)
`define PBMFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/pbmfe_pkg.sv =====
package pbmfe_pkg;

   localparam int unsigned SamplesPerAverageDefault = 64;
   localparam int unsigned DebounceResetVal         = 100;
   localparam int unsigned ProgramCountResetVal     = 30;
   localparam int unsigned SampleWidth              = 8;
   localparam int unsigned ValueWidth               = 7;
   localparam int unsigned DebounceWidth            = 8;
   localparam int unsigned VolumeShift              = 7;
   localparam int unsigned VolumeMax                = 127;
   localparam int unsigned MaxMsgs                  = 3;
   localparam int unsigned MsgCntWidth              = 2;

   typedef enum logic {
      MSG_VOLUME  = 1'b0,
      MSG_PROGRAM = 1'b1
   } msg_kind_type;

   typedef enum logic {
      CSR_DEBOUNCE_PERIOD = 1'b0,
      CSR_PROGRAM_COUNT   = 1'b1
   } csr_index_type;

   typedef struct packed {
      msg_kind_type          kind;
      logic [ValueWidth-1:0] value;
   } msg_type;

   typedef struct packed {
      logic                   load;
      logic [MsgCntWidth-1:0] n_msgs;
   } oq_load_type;

   typedef struct packed {
      logic can_load;
      logic last;
   } oq_status_type;

endpackage

// ===== hdl/pbmfe_outq.sv =====
module pbmfe_outq (
   input  logic                                           clock,
   input  logic                                           reset,
   input  pbmfe_pkg::oq_load_type                         load_i,
   input  pbmfe_pkg::msg_type [pbmfe_pkg::MaxMsgs-1:0]    msgs_i,
   output pbmfe_pkg::oq_status_type                       status_o,
   output logic                                           valid_o,
   input  logic                                           ready_i,
   output pbmfe_pkg::msg_type                             head_o
);

   logic [pbmfe_pkg::MsgCntWidth-1:0]          left_ff, left_in;
   pbmfe_pkg::msg_type [pbmfe_pkg::MaxMsgs-1:0] slot_ff, slot_in;
   logic                                        take;

   assign take    = (left_ff != '0) && ready_i;
   assign valid_o = (left_ff != '0);
   assign head_o  = slot_ff[0];

   assign status_o.can_load = (left_ff == '0) ||
                              ((left_ff == pbmfe_pkg::MsgCntWidth'(1)) && ready_i);
   assign status_o.last     = (left_ff == pbmfe_pkg::MsgCntWidth'(1));

   always_comb begin
      left_in = left_ff;
      slot_in = slot_ff;
      if (take) begin
         left_in = left_ff - pbmfe_pkg::MsgCntWidth'(1);
         for (int i = 0; i < int'(pbmfe_pkg::MaxMsgs) - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
      if (load_i.load) begin
         left_in = load_i.n_msgs;
         slot_in = msgs_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// ===== hdl/pedal_and_button_midi_front_end_core.sv =====
// A tick is taken into the input register and worked from there once the output queue can
// load; its first message is then presented from the output queue register.
// One tick per cycle while each tick yields at most one message and the result port is not
// stalled; a tick that yields more holds the next one until its last message is being taken.
// Reset (synchronous): averaging, sent volume and button state cleared, hysteresis direction
// up, program 30, debounce period 100, program count 30, no messages pending.
`include "pedal_and_button_midi_front_end_core_assert.svh"

module pedal_and_button_midi_front_end_core #(
   parameter int unsigned SAMPLES_PER_AVERAGE = pbmfe_pkg::SamplesPerAverageDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // pedal_sample[7:0], up_button_pressed[8],
                                   // down_button_pressed[9], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // msg_value[6:0], zero fill
   output logic [0:0]  rsp_tuser,  // msg_kind[0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int unsigned SumWidth = $clog2(SAMPLES_PER_AVERAGE * 255 + 1);
   localparam int unsigned CntWidth = $clog2(SAMPLES_PER_AVERAGE);
   localparam int unsigned QWidth   = SumWidth - pbmfe_pkg::VolumeShift;
   localparam int unsigned SatWidth = (QWidth > pbmfe_pkg::ValueWidth) ? QWidth
                                                                       : pbmfe_pkg::ValueWidth;
   localparam int unsigned VW       = pbmfe_pkg::ValueWidth;

   // configuration
   logic [pbmfe_pkg::DebounceWidth-1:0] debounce_period_ff;
   logic [VW-1:0]                       program_count_ff;

   // input register
   logic                                in_valid_ff;
   logic [pbmfe_pkg::SampleWidth-1:0]   in_sample_ff;
   logic                                in_up_ff;
   logic                                in_down_ff;

   // tick state
   logic [SumWidth-1:0]                 sample_sum_ff, sample_sum_in;
   logic [CntWidth-1:0]                 sample_count_ff, sample_count_in;
   logic [VW-1:0]                       sent_volume_ff, sent_volume_in;
   logic                                moving_up_ff, moving_up_in;
   logic [pbmfe_pkg::DebounceWidth-1:0] debounce_left_ff, debounce_left_in;
   logic                                up_held_ff, up_held_in;
   logic                                down_held_ff, down_held_in;
   logic [VW-1:0]                       program_number_ff, program_number_in;

   logic                                proc_fire;
   logic [SumWidth-1:0]                 sum_ext;
   logic [SatWidth-1:0]                 q_ext;
   logic [VW-1:0]                       vol;
   logic [VW:0]                         vol8;
   logic [VW:0]                         sent8;
   logic                                vol_send;
   logic [VW-1:0]                       modulus;
   logic [VW:0]                         pn_inc;
   logic [VW-1:0]                       pn;
   logic [pbmfe_pkg::MsgCntWidth-1:0]   n_msgs;

   pbmfe_pkg::msg_type [pbmfe_pkg::MaxMsgs-1:0] msgs;
   pbmfe_pkg::oq_load_type                      oq_load;
   pbmfe_pkg::oq_status_type                    oq_status;
   pbmfe_pkg::msg_type                          head;

   assign proc_fire  = in_valid_ff && oq_status.can_load;
   assign req_tready = !in_valid_ff || oq_status.can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_period_ff <= pbmfe_pkg::DebounceWidth'(pbmfe_pkg::DebounceResetVal);
         program_count_ff   <= VW'(pbmfe_pkg::ProgramCountResetVal);
      end else if (csr_we) begin
         case (pbmfe_pkg::csr_index_type'(csr_index))
            pbmfe_pkg::CSR_DEBOUNCE_PERIOD: debounce_period_ff <= csr_wdata;
            pbmfe_pkg::CSR_PROGRAM_COUNT:   program_count_ff   <= csr_wdata[VW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_sample_ff <= req_tdata[7:0];
         in_up_ff     <= req_tdata[8];
         in_down_ff   <= req_tdata[9];
      end
   end

   // volume averaging with hysteresis
   always_comb begin
      sum_ext         = sample_sum_ff + SumWidth'(in_sample_ff);
      q_ext           = SatWidth'(sum_ext >> pbmfe_pkg::VolumeShift);
      vol             = (q_ext > SatWidth'(pbmfe_pkg::VolumeMax)) ? VW'(pbmfe_pkg::VolumeMax)
                                                                   : q_ext[VW-1:0];
      vol8            = {1'b0, vol};
      sent8           = {1'b0, sent_volume_ff};
      sample_sum_in   = sum_ext;
      sample_count_in = sample_count_ff + CntWidth'(1);
      sent_volume_in  = sent_volume_ff;
      moving_up_in    = moving_up_ff;
      vol_send        = 1'b0;
      if (sample_count_ff == CntWidth'(SAMPLES_PER_AVERAGE - 1)) begin
         sample_sum_in   = '0;
         sample_count_in = '0;
         if (vol8 > sent8 + (VW+1)'(1)) begin
            moving_up_in = 1'b1;
         end
         if (vol8 + (VW+1)'(1) < sent8) begin
            moving_up_in = 1'b0;
         end
         vol_send = ((vol > sent_volume_ff) && moving_up_in) ||
                    ((vol < sent_volume_ff) && !moving_up_in);
         if (vol_send) begin
            sent_volume_in = vol;
         end
      end
   end

   // debounced buttons, program stepping and message list
   always_comb begin
      modulus          = (program_count_ff == '0) ? VW'(1) : program_count_ff;
      pn               = program_number_ff;
      pn_inc           = {1'b0, program_number_ff} + (VW+1)'(1);
      debounce_left_in = debounce_left_ff;
      up_held_in       = up_held_ff;
      down_held_in     = down_held_ff;
      msgs             = '0;
      n_msgs           = '0;
      if (vol_send) begin
         msgs[n_msgs] = '{kind: pbmfe_pkg::MSG_VOLUME, value: vol};
         n_msgs       = n_msgs + pbmfe_pkg::MsgCntWidth'(1);
      end
      if (debounce_left_ff != '0) begin
         debounce_left_in = debounce_left_ff - pbmfe_pkg::DebounceWidth'(1);
      end else begin
         debounce_left_in = debounce_period_ff;
         up_held_in       = in_up_ff;
         down_held_in     = in_down_ff;
         if (in_up_ff && !up_held_ff) begin
            pn           = (pn_inc > ({1'b0, modulus} - (VW+1)'(1))) ? '0 : pn_inc[VW-1:0];
            msgs[n_msgs] = '{kind: pbmfe_pkg::MSG_PROGRAM, value: pn};
            n_msgs       = n_msgs + pbmfe_pkg::MsgCntWidth'(1);
         end
         if (in_down_ff && !down_held_ff) begin
            pn           = ((pn == '0) ? modulus : pn) - VW'(1);
            msgs[n_msgs] = '{kind: pbmfe_pkg::MSG_PROGRAM, value: pn};
            n_msgs       = n_msgs + pbmfe_pkg::MsgCntWidth'(1);
         end
      end
      program_number_in = pn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_sum_ff     <= '0;
         sample_count_ff   <= '0;
         sent_volume_ff    <= '0;
         moving_up_ff      <= 1'b1;
         debounce_left_ff  <= '0;
         up_held_ff        <= 1'b0;
         down_held_ff      <= 1'b0;
         program_number_ff <= VW'(pbmfe_pkg::ProgramCountResetVal);
      end else if (proc_fire) begin
         sample_sum_ff     <= sample_sum_in;
         sample_count_ff   <= sample_count_in;
         sent_volume_ff    <= sent_volume_in;
         moving_up_ff      <= moving_up_in;
         debounce_left_ff  <= debounce_left_in;
         up_held_ff        <= up_held_in;
         down_held_ff      <= down_held_in;
         program_number_ff <= program_number_in;
      end
   end

   assign oq_load.load   = proc_fire;
   assign oq_load.n_msgs = n_msgs;

   pbmfe_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .load_i   (oq_load),
      .msgs_i   (msgs),
      .status_o (oq_status),
      .valid_o  (rsp_tvalid),
      .ready_i  (rsp_tready),
      .head_o   (head)
   );

   assign rsp_tdata = {1'b0, head.value};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = oq_status.last;

   `PBMFE_ASSERT_IMP(a_fire_room, clock, reset, proc_fire,
                     !rsp_tvalid || (rsp_tlast && rsp_tready))
   `PBMFE_ASSERT_NEXT(a_msgs_offered, clock, reset, proc_fire && (n_msgs != '0), rsp_tvalid)
   `PBMFE_ASSERT_NEXT(a_debounce_reload, clock, reset,
                      proc_fire && (debounce_left_ff == '0),
                      debounce_left_ff == $past(debounce_period_ff))
   `PBMFE_ASSERT_NEXT(a_volume_hold, clock, reset, !proc_fire, $stable(sent_volume_ff))

endmodule
